>>> rtl/core/wsfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared phase codes, header constants and the result record of the
// frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       data_valid;
        logic       ping_valid;
        logic       message_binary;
        logic       message_done;
        logic       pong_request;
        logic       close_request;
        logic       length_error;
        logic [3:0] frame_opcode;
    } t_result;

    function automatic logic is_data_op(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY);
    endfunction

endpackage

>>> rtl/core/websocket_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Byte-serial RFC 6455 frame deframer: header parse, unmasking, frame-end
// requests and length error detection.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while not stalled, and gives
// exactly one result in the next cycle, from a single result register after
// the parser logic. Input stall is raised only while that register holds a
// result the sink is stalling; otherwise a byte can enter every cycle, also
// while the held result is taken. After a bad 64-bit length every result
// carries only length_error (with message type and opcode) until reset.
module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_data_valid,
    output logic       o_ping_valid,
    output logic       o_message_binary,
    output logic       o_message_done,
    output logic       o_pong_request,
    output logic       o_close_request,
    output logic       o_length_error,
    output logic [3:0] o_frame_opcode
);

    logic    rx_accept;
    logic    out_full_stalled;
    t_result parse_result;
    t_result out_result;

    assign o_rx_stall = out_full_stalled;
    assign rx_accept  = i_rx_valid && !out_full_stalled;

    wsfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx_byte),
        .o_result  (parse_result)
    );

    wsfr_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (rx_accept),
        .i_result       (parse_result),
        .i_stall        (i_res_stall),
        .o_full_stalled (out_full_stalled),
        .o_valid        (o_res_valid),
        .o_result       (out_result)
    );

    assign o_payload_byte   = out_result.payload_byte;
    assign o_data_valid     = out_result.data_valid;
    assign o_ping_valid     = out_result.ping_valid;
    assign o_message_binary = out_result.message_binary;
    assign o_message_done   = out_result.message_done;
    assign o_pong_request   = out_result.pong_request;
    assign o_close_request  = out_result.close_request;
    assign o_length_error   = out_result.length_error;
    assign o_frame_opcode   = out_result.frame_opcode;

    a_one_payload_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_data_valid && o_ping_valid))
        else $error("data and ping flagged on the same byte");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_data_valid && !o_ping_valid) |-> (o_payload_byte == 8'd0))
        else $error("payload byte nonzero outside payload");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_length_error) |-> (!o_data_valid && !o_ping_valid &&
            !o_message_done && !o_pong_request && !o_close_request))
        else $error("length error result carries other flags");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_length_error && !i_res_stall) |=>
            (!o_res_valid || o_length_error))
        else $error("stream left halted state without reset");

endmodule

>>> rtl/core/wsfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_parser
// Header parser, length counter and payload unmasking; builds the result
// for each accepted byte and advances the frame state.
// ----------------------------------------------------------------------------
module wsfr_parser
    import wsfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_result    o_result
);

    logic [2:0]  r_phase,     n_phase;
    logic        r_final,     n_final;
    logic [3:0]  r_opcode,    n_opcode;
    logic        r_masked,    n_masked;
    logic [63:0] r_remaining, n_remaining;
    logic [3:0]  r_hdr_count, n_hdr_count;
    logic [31:0] r_key,       n_key;
    logic [1:0]  r_mask_index, n_mask_index;
    logic        r_binary,    n_binary;
    logic        r_dead,      n_dead;

    logic        hdr_done;
    logic        frm_end;
    logic [3:0]  cnt_dec;
    logic [1:0]  key_sel;
    logic [7:0]  key_byte;
    logic [7:0]  unmasked;
    logic [63:0] rem_dec;
    t_result     res;

    assign cnt_dec  = r_hdr_count - 4'd1;
    // first payload byte uses the most significant key byte
    assign key_sel  = ~r_mask_index;
    assign key_byte = r_key[{key_sel, 3'b000} +: 8];
    assign unmasked = i_rx_byte ^ key_byte;
    assign rem_dec  = (r_remaining != 64'd0) ? (r_remaining - 64'd1) : r_remaining;

    always_comb begin
        n_phase      = r_phase;
        n_final      = r_final;
        n_opcode     = r_opcode;
        n_masked     = r_masked;
        n_remaining  = r_remaining;
        n_hdr_count  = r_hdr_count;
        n_key        = r_key;
        n_mask_index = r_mask_index;
        n_binary     = r_binary;
        n_dead       = r_dead;
        hdr_done     = 1'b0;
        frm_end      = 1'b0;
        res          = '0;

        if (r_dead) begin
            res.length_error = 1'b1;
        end else begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_masked    = i_rx_byte[7];
                    n_key       = '0;
                    n_remaining = '0;
                    if (i_rx_byte[6:0] == LEN_EXT16) begin
                        n_hdr_count = EXT16_BYTES;
                        n_phase     = PH_EXT;
                    end else if (i_rx_byte[6:0] == LEN_EXT64) begin
                        n_hdr_count = EXT64_BYTES;
                        n_phase     = PH_EXT;
                    end else begin
                        n_remaining = {57'd0, i_rx_byte[6:0]};
                        if (i_rx_byte[7]) begin
                            n_hdr_count = KEY_BYTES;
                            n_phase     = PH_KEY;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    n_remaining = {r_remaining[55:0], i_rx_byte};
                    n_hdr_count = cnt_dec;
                    if (cnt_dec == 4'd0) begin
                        if (r_masked) begin
                            n_hdr_count = KEY_BYTES;
                            n_phase     = PH_KEY;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    n_key       = {r_key[23:0], i_rx_byte};
                    n_hdr_count = cnt_dec;
                    if (cnt_dec == 4'd0) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_PAY: begin
                    n_mask_index = r_mask_index + 2'd1;
                    if (is_data_op(r_opcode)) begin
                        res.payload_byte = unmasked;
                        res.data_valid   = 1'b1;
                    end else if (r_opcode == OP_PING) begin
                        res.payload_byte = unmasked;
                        res.ping_valid   = 1'b1;
                    end
                    n_remaining = rem_dec;
                    if (rem_dec == 64'd0) begin
                        frm_end = 1'b1;
                    end
                end
                default: begin
                    // first header byte, also taken for unused phase codes
                    n_final  = i_rx_byte[7];
                    n_opcode = i_rx_byte[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase

            if (hdr_done) begin
                if (n_remaining[63]) begin
                    n_dead           = 1'b1;
                    res.length_error = 1'b1;
                end else begin
                    n_mask_index = 2'd0;
                    if (r_opcode == OP_TEXT) begin
                        n_binary = 1'b0;
                    end else if (r_opcode == OP_BINARY) begin
                        n_binary = 1'b1;
                    end
                    if (n_remaining == 64'd0) begin
                        frm_end = 1'b1;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
            end

            if (frm_end) begin
                if (is_data_op(r_opcode)) begin
                    res.message_done = r_final;
                end else if (r_opcode == OP_PING) begin
                    res.pong_request = 1'b1;
                end else if (r_opcode != OP_PONG) begin
                    res.close_request = 1'b1;
                end
                n_phase = PH_HDR0;
            end
        end

        res.message_binary = n_binary;
        res.frame_opcode   = n_opcode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR0;
            r_final      <= 1'b0;
            r_opcode     <= '0;
            r_masked     <= 1'b0;
            r_remaining  <= '0;
            r_hdr_count  <= '0;
            r_key        <= '0;
            r_mask_index <= '0;
            r_binary     <= 1'b0;
            r_dead       <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_final      <= n_final;
            r_opcode     <= n_opcode;
            r_masked     <= n_masked;
            r_remaining  <= n_remaining;
            r_hdr_count  <= n_hdr_count;
            r_key        <= n_key;
            r_mask_index <= n_mask_index;
            r_binary     <= n_binary;
            r_dead       <= n_dead;
        end
    end

    assign o_result = res;

endmodule

>>> rtl/core/wsfr_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_out_reg
// Result register with valid/stall handshake; refills in the cycle the
// held result is taken.
// ----------------------------------------------------------------------------
module wsfr_out_reg
    import wsfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_full_stalled,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // a new result fits when the register is empty or drains this cycle
    assign o_full_stalled = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
